// File: rtl/gls_pkg.sv
// Shared types and codes for the grid line-of-sight block.
`default_nettype none

package gls_pkg;

    localparam int unsigned X_W    = 6;
    localparam int unsigned Y_W    = 5;
    localparam int unsigned CODE_W = 2;
    localparam int unsigned ERR_W  = 8;

    // Cell and blocking codes.
    localparam logic [CODE_W-1:0] CODE_OPEN = 2'd0;
    localparam logic [CODE_W-1:0] CODE_LOW  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_HARD = 2'd2;
    localparam logic [CODE_W-1:0] CODE_BAD  = 2'd3;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [X_W-1:0]    cell_x;
        logic [Y_W-1:0]    cell_y;
        logic [CODE_W-1:0] cell_code;
        logic [X_W-1:0]    from_x;
        logic [Y_W-1:0]    from_y;
        logic [X_W-1:0]    to_x;
        logic [Y_W-1:0]    to_y;
        logic              lobbed;
    } req_word_t;

    typedef struct packed {
        logic              visible;
        logic [CODE_W-1:0] block_code;
    } rsp_word_t;

    // Position and error term of the line walk.
    typedef struct packed {
        logic [X_W-1:0]          x;
        logic [Y_W-1:0]          y;
        logic signed [ERR_W-1:0] err;
    } walk_pos_t;

    // Fixed slope data of one walk.
    typedef struct packed {
        logic [X_W-1:0] dx;
        logic [Y_W-1:0] dy;
        logic           sx_neg;
        logic           sy_neg;
    } walk_slope_t;

endpackage

`default_nettype wire

// File: rtl/gls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gls_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/gls_step.sv
// One Bresenham step: next cell and error term from the current ones.
`default_nettype none

module gls_step (
    input  wire gls_pkg::walk_pos_t   cur,
    input  wire gls_pkg::walk_slope_t slope,
    output gls_pkg::walk_pos_t        nxt
);

    import gls_pkg::*;

    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] dx_s;
    logic signed [ERR_W:0] dy_s;
    logic signed [ERR_W:0] err_t;

    always_comb
    begin
        e2    = $signed({cur.err, 1'b0});
        dx_s  = $signed({3'b000, slope.dx});
        dy_s  = $signed({4'b0000, slope.dy});
        err_t = $signed({cur.err[ERR_W-1], cur.err});
        nxt   = cur;
        // advance x
        if (e2 > -dy_s)
        begin
            err_t = err_t - dy_s;
            nxt.x = slope.sx_neg ? cur.x - X_W'(1) : cur.x + X_W'(1);
        end
        // advance y
        if (e2 < dx_s)
        begin
            err_t = err_t + dx_s;
            nxt.y = slope.sy_neg ? cur.y - Y_W'(1) : cur.y + Y_W'(1);
        end
        nxt.err = err_t[ERR_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/grid_line_of_sight_top.sv
// Top level of the grid line-of-sight block: grid RAM, walk control, result register.
`default_nettype none

// Grid line of sight. The block keeps a GRID_W x GRID_H occupancy grid of
// 2-bit cell codes (open, low obstacle, hard obstacle) in one RAM and takes
// one request word at a time on req_*. A write word stores one cell (code
// three is stored as low, cells outside the grid are dropped) and answers
// with a response word of visible 0, block_code 0. A query word walks a
// Bresenham line from the start cell to the end cell, testing every cell in
// between but neither endpoint; a hard cell stops the line, and a low cell
// stops it unless the lobbed flag is set and it is the first low cell met.
// The walk issues one grid RAM read per step through the single read port,
// the step for the next cell overlapping the check of the previous one. In
// every case the response word turns valid as the result state passes it to
// the output register, and the input frees on that same edge. The response
// waits in an output register, so the block takes the next request while
// the last response is still stalled; a response that is still stalled when
// the next one is ready holds the block for the length of the stall. After
// reset the block runs a clearing pass over every cell of the grid and holds
// req_stall high until it ends.
module grid_line_of_sight_top #(
    parameter int unsigned GRID_W = 64,
    parameter int unsigned GRID_H = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire gls_pkg::req_word_t  req_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output gls_pkg::rsp_word_t       rsp_word
);

    import gls_pkg::*;

    localparam int unsigned DEPTH  = GRID_W * GRID_H;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    walk_pos_t           pos_reg, pos_next;
    walk_slope_t         slope_reg, slope_next;
    logic [X_W-1:0]      ex_reg, ex_next;
    logic [Y_W-1:0]      ey_reg, ey_next;
    logic                lob_reg, lob_next;
    logic                passed_reg, passed_next;
    logic                pend_reg, pend_next;
    logic                oob_reg, oob_next;
    rsp_word_t           res_reg, res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_word_reg, rsp_word_next;

    walk_pos_t           step_pos;
    walk_slope_t         load_slope;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CODE_W-1:0]   ram_wdata;
    logic [CODE_W-1:0]   ram_rdata;
    logic                rsp_free;
    logic [CODE_W-1:0]   cell_code;
    logic                step_oob;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [X_W-1:0] cx,
        input logic [Y_W-1:0] cy
    );
        return ADDR_W'(ADDR_W'(cy) * ADDR_W'(GRID_W)) + ADDR_W'(cx);
    endfunction

    function automatic logic in_grid(
        input logic [X_W-1:0] cx,
        input logic [Y_W-1:0] cy
    );
        return (9'(cx) < 9'(GRID_W)) && (9'(cy) < 9'(GRID_H));
    endfunction

    gls_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cell_addr(step_pos.x, step_pos.y)),
        .rdata (ram_rdata)
    );

    gls_step u_step (
        .cur   (pos_reg),
        .slope (slope_reg),
        .nxt   (step_pos)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign step_oob  = !in_grid(step_pos.x, step_pos.y);
    // cells off the grid read as low
    assign cell_code = oob_reg ? CODE_LOW : ram_rdata;

    always_comb
    begin
        load_slope.dx     = (req_word.to_x > req_word.from_x) ?
                            req_word.to_x - req_word.from_x :
                            req_word.from_x - req_word.to_x;
        load_slope.dy     = (req_word.to_y > req_word.from_y) ?
                            req_word.to_y - req_word.from_y :
                            req_word.from_y - req_word.to_y;
        load_slope.sx_neg = !(req_word.to_x > req_word.from_x);
        load_slope.sy_neg = !(req_word.to_y > req_word.from_y);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        slope_next     = slope_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        lob_next       = lob_reg;
        passed_next    = passed_reg;
        pend_next      = pend_reg;
        oob_next       = oob_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = CODE_OPEN;

        // drop the response word once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_word.kind == KIND_WRITE)
                    begin
                        ram_we    = in_grid(req_word.cell_x, req_word.cell_y);
                        ram_waddr = cell_addr(req_word.cell_x, req_word.cell_y);
                        ram_wdata = (req_word.cell_code == CODE_BAD) ?
                                    CODE_LOW : req_word.cell_code;
                        res_next.visible    = 1'b0;
                        res_next.block_code = CODE_OPEN;
                        state_next          = S_RESULT;
                    end
                    else if (req_word.from_x == req_word.to_x &&
                             req_word.from_y == req_word.to_y)
                    begin
                        res_next.visible    = 1'b1;
                        res_next.block_code = CODE_OPEN;
                        state_next          = S_RESULT;
                    end
                    else
                    begin
                        pos_next.x   = req_word.from_x;
                        pos_next.y   = req_word.from_y;
                        pos_next.err = ERR_W'($signed({2'b00, load_slope.dx}))
                                     - ERR_W'($signed({3'b000, load_slope.dy}));
                        slope_next   = load_slope;
                        ex_next      = req_word.to_x;
                        ey_next      = req_word.to_y;
                        lob_next     = req_word.lobbed;
                        passed_next  = 1'b0;
                        pend_next    = 1'b0;
                        oob_next     = 1'b0;
                        state_next   = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                // check the cell read last cycle before the step issued now
                if (pend_reg && cell_code == CODE_HARD)
                begin
                    res_next.visible    = 1'b0;
                    res_next.block_code = CODE_HARD;
                    state_next          = S_RESULT;
                end
                else if (pend_reg && cell_code != CODE_OPEN && !(lob_reg && !passed_reg))
                begin
                    res_next.visible    = 1'b0;
                    res_next.block_code = CODE_LOW;
                    state_next          = S_RESULT;
                end
                else
                begin
                    if (pend_reg && cell_code != CODE_OPEN)
                    begin
                        passed_next = 1'b1;
                    end
                    if (step_pos.x == ex_reg && step_pos.y == ey_reg)
                    begin
                        res_next.visible    = 1'b1;
                        res_next.block_code = CODE_OPEN;
                        state_next          = S_RESULT;
                    end
                    else
                    begin
                        pos_next  = step_pos;
                        pend_next = 1'b1;
                        oob_next  = step_oob;
                    end
                end
            end

            S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            passed_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            passed_reg    <= passed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        slope_reg    <= slope_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        lob_reg      <= lob_next;
        oob_reg      <= oob_next;
        res_reg      <= res_next;
        rsp_word_reg <= rsp_word_next;
    end

    // The grid is never written while a walk reads it.
    a_no_write_in_walk: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !ram_we
    ) else $error("grid written during a walk");

    // A new response word comes only out of the result stage.
    a_rsp_from_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_RESULT)
    ) else $error("response word without a finished item");

    // A visible line never carries a blocking code.
    a_visible_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && res_reg.visible) |-> (res_reg.block_code == CODE_OPEN)
    ) else $error("visible result with a blocking code");

    // A pending cell check only follows a walk step.
    a_pend_after_walk: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> ($past(state_reg) == S_WALK)
    ) else $error("cell check pending outside a walk");

    // A low cell is only passed with the lobbed flag set; the allowance is used at most once per walk.
    a_lob_once: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(passed_reg) |-> $past(lob_reg)
    ) else $error("low cell passed without lobbed flag");

endmodule

`default_nettype wire
